>>> hw/rtl/icmppt_pkg.sv
package icmppt_pkg;

  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned CURR_W   = 16;
  localparam int unsigned STEP_W   = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 40;

  // operand and product widths of the shared multiplier
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATT_VOLT_MAX    = 3'd0,
    REG_BATT_VOLT_CV     = 3'd1,
    REG_MPPT_CURRENT_CAP = 3'd2,
    REG_FUSE_CURRENT_CAP = 3'd3,
    REG_TRACK_STEP       = 3'd4,
    REG_COND_DEADBAND    = 3'd5,
    REG_BACKOFF_STEP     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [VOLT_W-1:0]        batt_volt_max;
    logic [VOLT_W-1:0]        batt_volt_cv;
    logic [CURR_W-1:0]        mppt_current_cap;
    logic [CURR_W-1:0]        fuse_current_cap;
    logic [STEP_W-1:0]        track_step;
    logic [15:0]              cond_deadband;
    logic signed [VOLT_W-1:0] backoff_step;
  } cfg_t;

  // operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SDI_V  = 2'd0,
    MUL_I_ADV  = 2'd1,
    MUL_DB_V   = 2'd2,
    MUL_Q_ADV  = 2'd3
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     finish;
  } dp_cmd_t;

endpackage

>>> hw/rtl/inccond_mppt_with_charge_limit_core.sv
// Incremental-conductance MPPT step with CC/CV charge limiting.
// Input beats on in_*: one sample of array voltage and current, battery
// voltage, charge current, BMS limit and boost enable. Each accepted beat
// yields exactly one result beat on out_*: voltage step, hard-stop, CV and
// CC flags and the effective current limit.
// One sample is worked on at a time; the next beat is taken only once the
// previous result has been registered. One shared 33x17 multiplier is used
// four times per sample, followed by a final add-and-compare step.
// The output register holds a finished result while out_tready is low; a new
// sample may be accepted and worked on meanwhile, and it waits in its last
// step until the output register frees up.
// Reset (rst_n low, synchronous) clears all configuration registers, the
// stored previous voltage and current, and the handshake state.
// Configuration: cfg_we writes cfg_wdata to register cfg_index. The user must
// write only while idle; the block itself has no check for this.
module inccond_mppt_with_charge_limit_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [icmppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icmppt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // array_voltage[15:0] array_current[31:16] battery_voltage[47:32]
  // charge_current[63:48] bms_current_limit[79:64] boost_enabled[80] zero[87:81]
  input  logic [icmppt_pkg::IN_DATA_W-1:0]    in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // voltage_step[15:0] hard_stop[16] cv_active[17] cc_active[18]
  // effective_limit[34:19] zero[39:35]
  output logic [icmppt_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import icmppt_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  icmppt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  icmppt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  icmppt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

>>> hw/rtl/icmppt_cfg.sv
module icmppt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [icmppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icmppt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output icmppt_pkg::cfg_t                    cfg
);
  import icmppt_pkg::*;

  cfg_t cfg_r;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATT_VOLT_MAX:    cfg_r.batt_volt_max    <= cfg_wdata;
        REG_BATT_VOLT_CV:     cfg_r.batt_volt_cv     <= cfg_wdata;
        REG_MPPT_CURRENT_CAP: cfg_r.mppt_current_cap <= cfg_wdata;
        REG_FUSE_CURRENT_CAP: cfg_r.fuse_current_cap <= cfg_wdata;
        REG_TRACK_STEP:       cfg_r.track_step       <= cfg_wdata[STEP_W-1:0];
        REG_COND_DEADBAND:    cfg_r.cond_deadband    <= cfg_wdata;
        REG_BACKOFF_STEP:     cfg_r.backoff_step     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/icmppt_ctrl.sv
module icmppt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output icmppt_pkg::dp_cmd_t  cmd
);
  import icmppt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   finish;

  assign in_tready = (state_r == S_IDLE);
  assign finish    = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_MUL4;
      S_MUL4: state_nxt = S_DONE;
      S_DONE: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath commands
  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_en  = 1'b1;
    cmd.finish  = finish;
    unique case (state_r)
      S_MUL1:  cmd.mul_sel = MUL_SDI_V;
      S_MUL2:  cmd.mul_sel = MUL_I_ADV;
      S_MUL3:  cmd.mul_sel = MUL_DB_V;
      S_MUL4:  cmd.mul_sel = MUL_Q_ADV;
      default: begin
        cmd.mul_sel = MUL_SDI_V;
        cmd.mul_en  = 1'b0;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hw/rtl/icmppt_dp.sv
module icmppt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  icmppt_pkg::cfg_t                     cfg,
  input  icmppt_pkg::dp_cmd_t                  cmd,
  input  logic [icmppt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic [icmppt_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import icmppt_pkg::*;

  // input fields
  logic [VOLT_W-1:0] in_v, in_bv;
  logic [CURR_W-1:0] in_i, in_chg, in_bms;
  logic              in_boost;

  assign in_v     = in_tdata[15:0];
  assign in_i     = in_tdata[31:16];
  assign in_bv    = in_tdata[47:32];
  assign in_chg   = in_tdata[63:48];
  assign in_bms   = in_tdata[79:64];
  assign in_boost = in_tdata[80];

  // previous sample
  logic [VOLT_W-1:0] last_v_r;
  logic [CURR_W-1:0] last_i_r;

  // per-item registers
  logic [VOLT_W-1:0]        v_r;
  logic [CURR_W-1:0]        i_r;
  logic signed [CURR_W:0]   sdi_r;
  logic [VOLT_W-1:0]        adv_r;
  logic                     dv_zero_r, di_zero_r, di_pos_r;
  logic [CURR_W-1:0]        limit_r;
  logic                     hard_r, cv_r, cc_r;
  logic signed [33:0]       p1_r;
  logic [31:0]              p2_r;
  logic [31:0]              q_r;
  logic [47:0]              rhs_r;
  logic [OUT_DATA_W-1:0]    out_r;

  // differences and limit at capture
  logic signed [VOLT_W:0] dv, di;
  logic [VOLT_W-1:0]      adv;
  logic signed [CURR_W:0] sdi;
  logic [CURR_W-1:0]      lim_a, limit;

  always_comb begin
    dv    = $signed({1'b0, in_v}) - $signed({1'b0, last_v_r});
    di    = $signed({1'b0, in_i}) - $signed({1'b0, last_i_r});
    adv   = dv[VOLT_W] ? VOLT_W'(-dv) : dv[VOLT_W-1:0];
    sdi   = dv[VOLT_W] ? -di : di;
    lim_a = (cfg.mppt_current_cap < in_bms) ? cfg.mppt_current_cap : in_bms;
    limit = (cfg.fuse_current_cap < lim_a) ? cfg.fuse_current_cap : lim_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_v_r <= '0;
      last_i_r <= '0;
    end else if (cmd.capture) begin
      last_v_r <= in_v;
      last_i_r <= in_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r       <= in_v;
      i_r       <= in_i;
      sdi_r     <= sdi;
      adv_r     <= adv;
      dv_zero_r <= (dv == '0);
      di_zero_r <= (di == '0);
      di_pos_r  <= !di[CURR_W] && (di != '0);
      limit_r   <= limit;
      hard_r    <= !in_boost || (in_bv >= cfg.batt_volt_max);
      cv_r      <= in_bv >= cfg.batt_volt_cv;
      cc_r      <= in_chg >= limit;
    end
  end

  // shared multiplier, one product per cycle
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SDI_V: begin
        mul_a = MUL_A_W'(sdi_r);
        mul_b = $signed({1'b0, v_r});
      end
      MUL_I_ADV: begin
        mul_a = $signed(MUL_A_W'(i_r));
        mul_b = $signed({1'b0, adv_r});
      end
      MUL_DB_V: begin
        mul_a = $signed(MUL_A_W'(cfg.cond_deadband));
        mul_b = $signed({1'b0, v_r});
      end
      MUL_Q_ADV: begin
        mul_a = $signed({1'b0, q_r});
        mul_b = $signed({1'b0, adv_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_SDI_V: p1_r  <= prod[33:0];
        MUL_I_ADV: p2_r  <= prod[31:0];
        MUL_DB_V:  q_r   <= prod[31:0];
        MUL_Q_ADV: rhs_r <= prod[47:0];
        default: ;
      endcase
    end
  end

  // conductance compare against the deadband
  logic signed [PROD_W-1:0] sum, lhs, rhs, rhs_neg;
  logic                     up, dn;
  logic signed [VOLT_W-1:0] ts, track, step;

  always_comb begin
    sum     = PROD_W'(p1_r) + $signed(PROD_W'(p2_r));
    lhs     = sum <<< 12;
    rhs     = $signed(PROD_W'(rhs_r));
    rhs_neg = -rhs;
    up      = lhs > rhs;
    dn      = lhs < rhs_neg;
    ts      = $signed({1'b0, cfg.track_step});
    if (dv_zero_r) begin
      if (di_zero_r)     track = '0;
      else if (di_pos_r) track = ts;
      else               track = -ts;
    end else begin
      if (up)            track = ts;
      else if (dn)       track = -ts;
      else               track = '0;
    end
    step = (cv_r || cc_r) ? cfg.backoff_step : track;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= {5'b0, limit_r, cc_r, cv_r, hard_r, step};
    end
  end

  assign out_tdata = out_r;

endmodule
